[hw/rtl/crfp_pkg.sv]
// Shared types, constants and helper functions for the camera reply frame parser.
// Depends on nothing; every other file refers to it by scoped names.
`default_nettype none

package crfp_pkg;

  localparam int BUFFER_DEPTH = 16;
  localparam int COUNT_W      = $clog2(BUFFER_DEPTH + 1);

  localparam logic [7:0] END_BYTE = 8'hFF;

  // Only frame bytes 2 to 9 are ever read back, so only those are kept.
  localparam int FIELD_FIRST = 2;
  localparam int FIELD_NUM   = 8;
  localparam int FIELD_IDX_W = $clog2(FIELD_NUM);

  // Counts held when the end byte arrives, one below the frame lengths 3, 7 and 11.
  localparam logic [COUNT_W-1:0] ACK_COUNT     = COUNT_W'(3 - 1);
  localparam logic [COUNT_W-1:0] ZOOM_COUNT    = COUNT_W'(7 - 1);
  localparam logic [COUNT_W-1:0] PANTILT_COUNT = COUNT_W'(11 - 1);
  localparam logic [COUNT_W-1:0] FULL_COUNT    = COUNT_W'(BUFFER_DEPTH);

  localparam logic [2:0] KIND_NONE    = 3'd0;
  localparam logic [2:0] KIND_ACK     = 3'd1;
  localparam logic [2:0] KIND_ZOOM    = 3'd2;
  localparam logic [2:0] KIND_PANTILT = 3'd3;
  localparam logic [2:0] KIND_UNKNOWN = 3'd4;

  typedef logic [FIELD_NUM-1:0][7:0] field_bytes_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [15:0]        zoom;
    logic signed [15:0] pan;
    logic signed [15:0] tilt;
  } reply_t;

  // Four bytes weighted by nibble positions; wide bytes overlap and wrap.
  function automatic logic [15:0] nibble_sum(input logic [7:0] b0, input logic [7:0] b1,
                                             input logic [7:0] b2, input logic [7:0] b3);
    logic [15:0] s;
    s = {b0[3:0], 12'h000} + {b1, 8'h00} + {4'h0, b2, 4'h0} + {8'h00, b3};
    return s;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/crfp_classify.sv]
// Combinational classification of the frame that an end byte closes.
// Depends on crfp_pkg for the count constants, kinds and reply_t.
`default_nettype none

module crfp_classify (
  input  wire logic [7:0]                  rx_byte,
  input  wire logic [crfp_pkg::COUNT_W-1:0] count,
  input  wire crfp_pkg::field_bytes_t       fields,
  output crfp_pkg::reply_t                  reply
);

  always_comb begin
    reply = '0;
    if (rx_byte == crfp_pkg::END_BYTE) begin
      unique case (count)
        crfp_pkg::ACK_COUNT: begin
          reply.kind = crfp_pkg::KIND_ACK;
        end
        crfp_pkg::ZOOM_COUNT: begin
          reply.kind = crfp_pkg::KIND_ZOOM;
          reply.zoom = crfp_pkg::nibble_sum(fields[0], fields[1], fields[2], fields[3]);
        end
        crfp_pkg::PANTILT_COUNT: begin
          reply.kind = crfp_pkg::KIND_PANTILT;
          reply.pan  = crfp_pkg::nibble_sum(fields[0], fields[1], fields[2], fields[3]);
          reply.tilt = crfp_pkg::nibble_sum(fields[4], fields[5], fields[6], fields[7]);
        end
        default: begin
          reply.kind = crfp_pkg::KIND_UNKNOWN;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[hw/rtl/camera_reply_frame_parser.sv]
// Latency: a result is valid in the cycle after its byte's request is accepted.
// Throughput: one byte per cycle unless a result waits on out_ready; the byte
// count register feeds the next byte's decode; a taken result frees the output.
// Reset clears the byte count and the result valid flag and sets the camera
// number to 1; stored frame bytes are not cleared.
// Depends on crfp_pkg and crfp_classify.
`default_nettype none

module camera_reply_frame_parser (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         rx_byte,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              reply_kind,
  output logic [15:0]             zoom_value,
  output logic signed [15:0]      pan_units,
  output logic signed [15:0]      tilt_units
);

  logic [2:0]                  camera_number;
  logic [crfp_pkg::COUNT_W-1:0] count;
  logic [crfp_pkg::COUNT_W-1:0] count_next;
  crfp_pkg::field_bytes_t       fields;
  crfp_pkg::reply_t             reply;
  logic [7:0]                   header;
  logic                         accept;
  logic                         store_field;
  logic [crfp_pkg::COUNT_W-1:0] field_offset;

  assign header   = {1'b1, camera_number, 4'h0};
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    count_next  = count;
    store_field = 1'b0;
    if (rx_byte == crfp_pkg::END_BYTE) begin
      count_next = '0;
    end else if (rx_byte == header) begin
      count_next = crfp_pkg::COUNT_W'(1);
    end else if (count < crfp_pkg::FULL_COUNT) begin
      count_next  = count + crfp_pkg::COUNT_W'(1);
      store_field = (count >= crfp_pkg::COUNT_W'(crfp_pkg::FIELD_FIRST)) &&
                    (count < crfp_pkg::COUNT_W'(crfp_pkg::FIELD_FIRST + crfp_pkg::FIELD_NUM));
    end
  end

  assign field_offset = count - crfp_pkg::COUNT_W'(crfp_pkg::FIELD_FIRST);

  always_ff @(posedge clk) begin
    if (rst) begin
      camera_number <= 3'd1;
    end else if (cfg_we) begin
      camera_number <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && store_field) begin
      fields[field_offset[crfp_pkg::FIELD_IDX_W-1:0]] <= rx_byte;
    end
  end

  crfp_classify u_classify (
    .rx_byte (rx_byte),
    .count   (count),
    .fields  (fields),
    .reply   (reply)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      reply_kind <= reply.kind;
      zoom_value <= reply.zoom;
      pan_units  <= reply.pan;
      tilt_units <= reply.tilt;
    end
  end

`ifndef NO_ASSERTIONS
  a_end_clears_count: assert property (@(posedge clk) disable iff (rst)
    accept && rx_byte == crfp_pkg::END_BYTE |=> count == '0)
    else $error("Byte count not cleared after an end byte.");

  a_header_restarts: assert property (@(posedge clk) disable iff (rst)
    accept && rx_byte != crfp_pkg::END_BYTE && rx_byte == header
    |=> count == crfp_pkg::COUNT_W'(1))
    else $error("Header byte did not restart the frame.");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("Accepted request produced no result.");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    accept |=> count <= crfp_pkg::FULL_COUNT)
    else $error("Byte count ran past the buffer depth.");

  a_zoom_only_for_zoom: assert property (@(posedge clk) disable iff (rst)
    out_valid && reply_kind != crfp_pkg::KIND_ZOOM |-> zoom_value == 16'h0000)
    else $error("Zoom value set on a reply that is not a zoom reply.");
`endif

endmodule

`default_nettype wire
